// ===== rtl/core/tcw_pkg.sv =====
// tcw_pkg: shared types, constants and codes of the text console writer
// no dependencies; used by every file in rtl/core

package tcw_pkg;

  // screen geometry
  localparam int unsigned Columns = 80;
  localparam int unsigned Rows    = 25;
  localparam int unsigned Cells   = Rows * Columns;
  localparam int unsigned AddrW   = $clog2(Cells);

  // field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned CharW     = 8;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned CellAddrW = 11;
  localparam int unsigned RowW      = 5;
  localparam int unsigned ColW      = 7;
  localparam int unsigned CellW     = CharW + ColorW;

  // character codes and register reset
  localparam logic [CharW-1:0]  NewlineCode    = 8'd10;
  localparam logic [CharW-1:0]  SpaceCode      = 8'd32;
  localparam logic [ColorW-1:0] TextColorReset = 8'd15;

  typedef enum logic [OpW-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // command class decided by the front
  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_e;

  // back sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCROLL,
    S_SCROLL_END,
    S_FILL,
    S_TAIL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [CharW-1:0]     character;
    logic [CellAddrW-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0]  cell_character;
    logic [ColorW-1:0] cell_color;
    logic [RowW-1:0]   cursor_row;
    logic [ColW-1:0]   cursor_column;
  } out_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] character;
    logic [AddrW-1:0] address;
  } cmd_t;

endpackage

// ===== rtl/core/tcw_front.sv =====
// tcw_front: accepts input items, classifies them and queues them for the back
// depends on tcw_pkg

module tcw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tcw_pkg::in_item_t  in_i,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output tcw_pkg::cmd_t      cmd_o
);

  tcw_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push_ok, pop_ok;
  tcw_pkg::cmd_t cls;

  // classification
  always_comb begin
    cls.character = in_i.character;
    cls.address   = tcw_pkg::AddrW'(in_i.cell_address);
    unique case (in_i.op)
      tcw_pkg::OP_PUT: begin
        cls.kind = (in_i.character == tcw_pkg::NewlineCode) ? tcw_pkg::K_NEWLINE
                                                             : tcw_pkg::K_CHAR;
      end
      tcw_pkg::OP_CLEAR: cls.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ: begin
        cls.kind = (32'(in_i.cell_address) < tcw_pkg::Cells) ? tcw_pkg::K_READ
                                                             : tcw_pkg::K_NOP;
      end
      default: cls.kind = tcw_pkg::K_NOP;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/tcw_back.sv =====
// tcw_back: cursor, screen store and sequencer for writes, scrolls, clears, reads
// depends on tcw_pkg; fed by tcw_front

module tcw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  tcw_pkg::cmd_t                 cmd_i,
  input  logic [tcw_pkg::ColorW-1:0]    text_color_i,
  output logic                          empty,
  input  logic                          pop,
  output tcw_pkg::out_item_t            out_o
);

  localparam int unsigned AddrW = tcw_pkg::AddrW;
  localparam logic [AddrW-1:0] ScrollLast = AddrW'(tcw_pkg::Cells - tcw_pkg::Columns - 1);
  localparam logic [AddrW-1:0] LastRowBase = AddrW'((tcw_pkg::Rows - 1) * tcw_pkg::Columns);
  localparam logic [AddrW-1:0] CellLast = AddrW'(tcw_pkg::Cells - 1);
  localparam logic [AddrW-1:0] RowStride = AddrW'(tcw_pkg::Columns);

  tcw_pkg::state_e state_q, state_d;

  logic [tcw_pkg::RowW-1:0]  row_q, row_d;
  logic [tcw_pkg::ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0]          ptr_q, ptr_d;
  logic [AddrW-1:0]          wa_q, wa_d;
  logic                      wv_q, wv_d;
  logic                      pend_q, pend_d;
  logic [tcw_pkg::CharW-1:0] char_q, char_d;
  logic [AddrW-1:0]          rd_addr_q, rd_addr_d;
  logic                      rd_flag_q, rd_flag_d;
  tcw_pkg::out_item_t        out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic [tcw_pkg::CellW-1:0] mem [tcw_pkg::Cells];
  logic [tcw_pkg::CellW-1:0] rdata_q;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_wa, mem_ra;
  logic [tcw_pkg::CellW-1:0] mem_wd;

  logic                      full_line, last_row, slot_free;
  logic [tcw_pkg::RowW-1:0]  put_row;
  logic [tcw_pkg::ColW-1:0]  put_col;
  logic [AddrW-1:0]          put_addr;

  assign full_line = (col_q == tcw_pkg::ColW'(tcw_pkg::Columns));
  assign last_row  = (row_q == tcw_pkg::RowW'(tcw_pkg::Rows - 1));
  assign put_row   = full_line ? row_q + 1'b1 : row_q;
  assign put_col   = full_line ? '0 : col_q;
  assign put_addr  = AddrW'(put_row * tcw_pkg::Columns) + AddrW'(put_col);
  assign slot_free = !out_valid_q || pop;
  assign empty     = !out_valid_q;
  assign out_o     = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            tcw_pkg::K_CHAR:    state_d = (full_line && last_row) ? tcw_pkg::S_SCROLL
                                                                  : tcw_pkg::S_EMIT;
            tcw_pkg::K_NEWLINE: state_d = last_row ? tcw_pkg::S_SCROLL : tcw_pkg::S_EMIT;
            tcw_pkg::K_CLEAR:   state_d = tcw_pkg::S_FILL;
            default:            state_d = tcw_pkg::S_EMIT;
          endcase
        end
      end
      tcw_pkg::S_SCROLL: begin
        if (ptr_q == ScrollLast) begin
          state_d = tcw_pkg::S_SCROLL_END;
        end
      end
      tcw_pkg::S_SCROLL_END: state_d = tcw_pkg::S_FILL;
      tcw_pkg::S_FILL: begin
        if (ptr_q == CellLast) begin
          state_d = pend_q ? tcw_pkg::S_TAIL : tcw_pkg::S_EMIT;
        end
      end
      tcw_pkg::S_TAIL: state_d = tcw_pkg::S_EMIT;
      tcw_pkg::S_EMIT: begin
        if (slot_free) begin
          state_d = tcw_pkg::S_IDLE;
        end
      end
      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    ptr_d       = ptr_q;
    wa_d        = wa_q;
    wv_d        = wv_q;
    pend_d      = pend_q;
    char_d      = char_q;
    rd_addr_d   = rd_addr_q;
    rd_flag_d   = rd_flag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = wa_q;
    mem_wd      = rdata_q;
    mem_ra      = rd_addr_q;
    unique case (state_q)
      tcw_pkg::S_IDLE: begin
        mem_ra = cmd_i.address;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rd_addr_d = cmd_i.address;
          rd_flag_d = (cmd_i.kind == tcw_pkg::K_READ);
          pend_d    = 1'b0;
          ptr_d     = '0;
          wv_d      = 1'b0;
          case (cmd_i.kind)
            tcw_pkg::K_CHAR: begin
              if (full_line && last_row) begin
                col_d  = '0;
                pend_d = 1'b1;
                char_d = cmd_i.character;
              end else begin
                mem_we = 1'b1;
                mem_wa = put_addr;
                mem_wd = {text_color_i, cmd_i.character};
                row_d  = put_row;
                col_d  = put_col + 1'b1;
              end
            end
            tcw_pkg::K_NEWLINE: begin
              col_d = '0;
              if (!last_row) begin
                row_d = row_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tcw_pkg::S_SCROLL: begin
        // read one row below, write back the previous read
        mem_ra = ptr_q + RowStride;
        mem_we = wv_q;
        wa_d   = ptr_q;
        wv_d   = 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end
      tcw_pkg::S_SCROLL_END: begin
        mem_we = wv_q;
        wv_d   = 1'b0;
        ptr_d  = LastRowBase;
      end
      tcw_pkg::S_FILL: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        mem_wd = {text_color_i, tcw_pkg::SpaceCode};
        ptr_d  = ptr_q + 1'b1;
      end
      tcw_pkg::S_TAIL: begin
        mem_we = 1'b1;
        mem_wa = LastRowBase;
        mem_wd = {text_color_i, char_q};
        col_d  = tcw_pkg::ColW'(1);
        pend_d = 1'b0;
      end
      tcw_pkg::S_EMIT: begin
        if (slot_free) begin
          out_d.cell_character = rd_flag_q ? rdata_q[tcw_pkg::CharW-1:0] : '0;
          out_d.cell_color     = rd_flag_q ? rdata_q[tcw_pkg::CellW-1:tcw_pkg::CharW] : '0;
          out_d.cursor_row     = row_q;
          out_d.cursor_column  = col_q;
          out_valid_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      wv_q        <= 1'b0;
      pend_q      <= 1'b0;
      rd_flag_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      wv_q        <= wv_d;
      pend_q      <= pend_d;
      rd_flag_q   <= rd_flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    wa_q      <= wa_d;
    char_q    <= char_d;
    rd_addr_q <= rd_addr_d;
    out_q     <= out_d;
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= tcw_pkg::ColW'(tcw_pkg::Columns))
    else $error("cursor column beyond line end");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= tcw_pkg::RowW'(tcw_pkg::Rows - 1))
    else $error("cursor row beyond last row");

  a_emit_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::S_EMIT |-> !mem_we)
    else $error("store written while a result is pending");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tcw_pkg::S_EMIT)
    else $error("result produced outside emit state");

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text_console_writer: top level of the text console engine
// depends on tcw_pkg, tcw_front, tcw_back
//
// Text-mode console of 25 rows by 80 columns. Each cell keeps a character and
// an attribute byte (foreground low nibble, background high nibble); the
// attribute applied to new cells is the text_color register (reset 15); the
// user must write it through the cfg channel only while the block is idle (not
// enforced by the block). Items enter through a queue-style port (push/full)
// and every item gives exactly one result (empty/pop) with the cursor after the
// operation and, for a read, the cell contents (zero otherwise and for reads
// past the last cell). A put, a newline that does not scroll, a read or an
// unused op goes from idle straight to emit. A newline on the last row, or a
// put with a full last row, scrolls: the store is walked once to move every row
// up and once over the bottom row to blank it. A clear blanks all 2000 cells
// and leaves the cursor in place. These walks go one cell per cycle through the
// single write port of the screen store. A two-entry command queue in front
// keeps taking items while the sequencer is busy or a result waits. The store
// comes up unwritten; read a cell only after a clear or a put has set it.

module text_console_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input item transfer
  input  logic                          push,
  output logic                          full,
  input  tcw_pkg::in_item_t             in_i,
  // result transfer
  output logic                          empty,
  input  logic                          pop,
  output tcw_pkg::out_item_t            out_o,
  // text_color register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::ColorW-1:0]    cfg_data_i
);

  logic                       cmd_valid;
  logic                       cmd_pop;
  tcw_pkg::cmd_t              cmd;
  logic [tcw_pkg::ColorW-1:0] text_color_q, text_color_d;

  // register write always completes in one transfer
  assign cfg_ready_o  = 1'b1;
  assign text_color_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : text_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::TextColorReset;
    end else begin
      text_color_q <= text_color_d;
    end
  end

  // front: accept and classify, queue commands
  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // back: cursor, store walks and result register
  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .text_color_i (text_color_q),
    .empty        (empty),
    .pop          (pop),
    .out_o        (out_o)
  );

endmodule

// ===== verif/tcw_console_tracker_pkg.sv =====
// console tracker: expected-result bookkeeping for the text console writer bench
// depends on tcw_pkg for geometry, item types and op codes
`timescale 1ns / 100ps

package tcw_console_tracker_pkg;
  import tcw_pkg::*;

  class console_tracker;
    logic [CharW-1:0]  char_mem  [Cells];
    logic [ColorW-1:0] color_mem [Cells];
    int unsigned       row;
    int unsigned       col;
    logic [ColorW-1:0] color;
    out_item_t         due_reports[$];
    int unsigned       failures;

    function new();
      row      = 0;
      col      = 0;
      color    = TextColorReset;
      failures = 0;
    endfunction

    function void set_color(logic [ColorW-1:0] value);
      color = value;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    function void blank_row(int unsigned r);
      for (int unsigned c = 0; c < Columns; c++) begin
        char_mem[r * Columns + c]  = SpaceCode;
        color_mem[r * Columns + c] = color;
      end
    endfunction

    // column back to 0; past the last row the screen moves up one row
    function void new_line();
      col = 0;
      if (row < Rows - 1) begin
        row++;
      end else begin
        for (int unsigned i = 0; i < Cells - Columns; i++) begin
          char_mem[i]  = char_mem[i + Columns];
          color_mem[i] = color_mem[i + Columns];
        end
        blank_row(Rows - 1);
      end
    endfunction

    // apply one accepted command and queue the report it must produce
    function void note_command(in_item_t cmd);
      out_item_t rep;
      rep = '0;
      case (cmd.op)
        OP_PUT: begin
          if (cmd.character == NewlineCode) begin
            new_line();
          end else begin
            if (col >= Columns) new_line();
            char_mem[row * Columns + col]  = cmd.character;
            color_mem[row * Columns + col] = color;
            col++;
          end
        end
        OP_CLEAR: begin
          for (int unsigned r = 0; r < Rows; r++) blank_row(r);
        end
        OP_READ: begin
          if (cmd.cell_address < Cells) begin
            rep.cell_character = char_mem[cmd.cell_address];
            rep.cell_color     = color_mem[cmd.cell_address];
          end
        end
        default: ;
      endcase
      rep.cursor_row    = RowW'(row);
      rep.cursor_column = ColW'(col);
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      want = due_reports.pop_front();
      compare_field("cell_character", 16'(want.cell_character), 16'(got.cell_character));
      compare_field("cell_color", 16'(want.cell_color), 16'(got.cell_color));
      compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
      compare_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for text_console_writer
// depends on tcw_pkg and tcw_console_tracker_pkg; drives commands and checks every result
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;
  import tcw_console_tracker_pkg::*;

  // opcode the block must ignore
  localparam logic [OpW-1:0] OpUnused   = 2'd3;
  localparam int unsigned    PhaseItems = 435;
  localparam int unsigned    CycleLimit = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  in_item_t           in_i;
  logic               empty;
  logic               pop;
  out_item_t          out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ColorW-1:0]  cfg_data_i;

  console_tracker     tracker;
  int unsigned        idle_pct;
  int unsigned        stall_pct;
  int unsigned        hold_len;
  int unsigned        cycle_count = 0;

  // per-phase sender gaps, receiver stalls (percent of cycles) and text color
  int unsigned        phase_idle  [4] = '{0, 68, 0, 36};
  int unsigned        phase_stall [4] = '{0, 0, 68, 36};
  logic [ColorW-1:0]  phase_color [4];

  text_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog on the cycle counter
  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  // monitor: everything is sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // color write transfer updates the tracked attribute
      if (cfg_valid_i && cfg_ready_o) tracker.set_color(cfg_data_i);
      // accepted command: predict its report
      if (push && !full) tracker.note_command(in_i);
      // accepted result: compare against the oldest prediction
      if (pop && !empty) tracker.check_report(out_o);
    end
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin : result_drain
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        // long hold-off so the command queue fills and full rises
        pop <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t pack_command(logic [OpW-1:0] op, logic [CharW-1:0] ch,
                                            logic [CellAddrW-1:0] addr);
    in_item_t cmd;
    cmd.op           = op;
    cmd.character    = ch;
    cmd.cell_address = addr;
    return cmd;
  endfunction

  // mostly text with newlines and reads, some clears, a little noise
  function automatic in_item_t random_command();
    int unsigned          pick;
    int unsigned          where;
    logic [CharW-1:0]     ch;
    logic [CellAddrW-1:0] addr;
    pick = $urandom_range(999);
    ch   = CharW'($urandom_range(255));
    addr = CellAddrW'($urandom_range(2047));
    if (pick < 10) return pack_command(OP_CLEAR, ch, addr);
    if (pick < 30) return pack_command(OpUnused, ch, addr);
    if (pick < 270) begin
      where = $urandom_range(9);
      // reads near the cursor row catch fresh writes and scrolled rows
      if (where < 5)
        addr = CellAddrW'(tracker.row * Columns + $urandom_range(Columns - 1));
      else if (where < 9)
        addr = CellAddrW'($urandom_range(Cells - 1));
      else
        addr = CellAddrW'($urandom_range(2047, Cells));
      return pack_command(OP_READ, ch, addr);
    end
    if (pick < 310)
      ch = NewlineCode;
    else if (pick >= 380)
      ch = CharW'($urandom_range(126, 32));
    return pack_command(OP_PUT, ch, addr);
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer,
  // push left high so back-to-back commands need no extra assignment
  task automatic offer_command(in_item_t cmd);
    in_i <= cmd;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random sender gaps at the current idle rate
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // sender pause until every predicted result has come back
  task automatic drain_results();
    push <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // text_color write while the block is idle
  task automatic write_text_color(logic [ColorW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    tracker     = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_len    = 0;
    // color extremes, then two random settings
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = ColorW'($urandom_range(255));
    phase_color[3] = ColorW'($urandom_range(255));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset color
    // character extremes; put ignores the address
    offer_command(pack_command(OP_PUT, 8'h00, '0));
    offer_command(pack_command(OP_PUT, 8'hFF, 11'h7FF));
    // only cells just written are readable before the first clear
    offer_command(pack_command(OP_READ, 8'h00, 11'd0));
    offer_command(pack_command(OP_READ, 8'hFF, 11'd1));
    // unused opcode: no effect, zero cell fields
    offer_command(pack_command(OpUnused, 8'hFF, 11'h7FF));
    // highest address is out of range
    offer_command(pack_command(OP_READ, 8'h00, 11'h7FF));
    offer_command(pack_command(OP_PUT, NewlineCode, '0));
    offer_command(pack_command(OP_PUT, 8'h41, '0));
    // clear keeps the cursor in place
    offer_command(pack_command(OP_CLEAR, 8'hA5, 11'h555));
    offer_command(pack_command(OP_READ, 8'h00, 11'd0));
    offer_command(pack_command(OP_READ, 8'h00, 11'd81));
    offer_command(pack_command(OP_READ, 8'h00, CellAddrW'(Cells - 1)));
    // first address past the last cell
    offer_command(pack_command(OP_READ, 8'h00, CellAddrW'(Cells)));

    // random phases; text wraps and scrolls happen naturally on the last row
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_text_color(phase_color[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      // long result hold-off while commands keep coming
      if (p == 0) hold_len = 400;
      for (int n = 0; n < PhaseItems; n++) begin
        sender_gap();
        offer_command(random_command());
      end
    end

    drain_results();
    repeat (20) @(negedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== text_console_writer.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
verif/tcw_console_tracker_pkg.sv
verif/tb_top.sv
